FILE: rtl/uispc_pkg.sv
// Package with types and constants for the screen power and input poll controller.
package uispc_pkg;

    // Poll event kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        OP_CHECK   = 2'd0,
        OP_ENCODER = 2'd1,
        OP_TOUCH   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_TIMEOUT   = 2'd0,
        REG_BRIGHT    = 2'd1,
        REG_PKEY_DEB  = 2'd2,
        REG_EKEY_DEB  = 2'd3
    } t_reg_idx;

    // Power key debounce phases.
    typedef enum logic [2:0] {
        PK_RELEASED = 3'b001,
        PK_ARMED    = 3'b010,
        PK_HELD     = 3'b100
    } t_pkey_phase;

    localparam int unsigned MS_PER_SEC     = 1000;
    localparam int unsigned TIMEOUT_MS_W   = 26;

    localparam logic [6:0] BRIGHT_MAX      = 7'd100;
    localparam logic [6:0] BRIGHT_MIN      = 7'd5;
    localparam logic [7:0] DUTY_FULL       = 8'd255;
    // Reciprocal of 100 scaled by 2^22; exact floor for products up to 25500.
    localparam logic [15:0] DUTY_RECIP     = 16'd41944;
    localparam int unsigned DUTY_SHIFT     = 22;

    localparam logic [6:0] BRIGHT_RESET    = 7'd100;
    localparam logic [9:0] PKEY_DEB_RESET  = 10'd50;
    localparam logic [9:0] EKEY_DEB_RESET  = 10'd30;

    localparam logic [14:0] STEPS_MAX      = 15'sd16383;
    localparam logic [14:0] STEPS_MIN      = 15'h4000;

    // Packed result word as it leaves on the master-side tdata.
    typedef struct packed {
        logic [7:0]  touch_y;
        logic [8:0]  touch_x;
        logic        touch_pressed;
        logic        encoder_key_pressed;
        logic [14:0] encoder_steps;
        logic [7:0]  backlight_duty;
        logic        screen_is_off;
    } t_result;

endpackage

FILE: rtl/ui_input_screen_power_controller_top.sv
// Screen power and input poll controller: one result word for every poll word.
// An accepted word is held in the input register; its result is computed from it and
// registered in the output register once the output side is not stalled.
// Throughput: one word per cycle while the output side is not stalled; the per-word update is one combinational pass.
// Reset: synchronous, active low; all state returns to its defaults at once,
// with no clearing pass, and words are accepted in the first cycle after reset.
module ui_input_screen_power_controller_top #(
    parameter int DETENT_COUNTS = 4,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Poll words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: now_ms[31:0], power_key_level, encoder_count[15:0],
    // encoder_key_level, touch_present, touch_x_raw[15:0], touch_y_raw[15:0], zero pad.
    input  logic [87:0] s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: screen_is_off, backlight_duty[7:0], encoder_steps[14:0],
    // encoder_key_pressed, touch_pressed, touch_x[8:0], touch_y[7:0], zero pad.
    output logic [47:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int REM_W      = $clog2(DETENT_COUNTS) + 1;
    localparam int DIV_SHIFT  = 21;
    localparam logic [21:0] DIV_RECIP =
        22'(((1 << DIV_SHIFT) + DETENT_COUNTS - 1) / DETENT_COUNTS);
    localparam logic [4:0]  DETENT_C  = 5'(DETENT_COUNTS);
    localparam logic [15:0] X_MAX     = 16'(SCREEN_WIDTH - 1);
    localparam logic [15:0] Y_MAX     = 16'(SCREEN_HEIGHT - 1);

    // Configuration registers.
    logic [15:0]                       r_timeout_s;
    logic [uispc_pkg::TIMEOUT_MS_W-1:0] r_timeout_ms;
    logic [6:0]                        r_bright;
    logic [7:0]                        r_duty;
    logic [9:0]                        r_pkey_deb;
    logic [9:0]                        r_ekey_deb;

    // Block state.
    logic                   r_off,         n_off;
    logic [31:0]            r_last_act,    n_last_act;
    logic                   r_restart,     n_restart;
    uispc_pkg::t_pkey_phase r_pk_phase,    n_pk_phase;
    logic [31:0]            r_pk_since,    n_pk_since;
    logic [15:0]            r_enc_last,    n_enc_last;
    logic [REM_W-1:0]       r_rem,         n_rem;
    logic                   r_ekey_raw,    n_ekey_raw;
    logic                   r_ekey_stable, n_ekey_stable;
    logic [31:0]            r_ekey_since,  n_ekey_since;
    logic                   r_swallow,     n_swallow;

    // Input and output registers.
    logic                   r_in_valid;
    logic [87:0]            r_in_data;
    logic [1:0]             r_in_op;
    logic                   r_out_valid;
    uispc_pkg::t_result     r_out,         n_out;

    logic                   advance;
    logic                   cfg_wr;
    uispc_pkg::t_reg_idx    cfg_idx;

    // Fields of the held input word.
    logic [31:0] in_now;
    logic        in_pwr;
    logic [15:0] in_cnt;
    logic        in_key;
    logic        in_present;
    logic [15:0] in_tx;
    logic [15:0] in_ty;

    // Configuration write datapath.
    logic [6:0]  bright_eff;
    logic [14:0] duty_prod;
    logic [30:0] duty_scaled;
    logic [25:0] timeout_ms_wr;

    // Encoder datapath.
    logic [15:0] enc_delta;
    logic [16:0] enc_acc;
    logic        enc_neg;
    logic [16:0] enc_mag_full;
    logic [15:0] enc_mag;
    logic [37:0] enc_prod;
    logic [15:0] q_mag;
    logic [20:0] q_times_d;
    logic [15:0] rem_mag;
    logic [16:0] q_signed;
    logic [16:0] rem_signed;
    logic [14:0] steps_sat;
    logic        step_nonzero;

    logic [31:0] elapsed;

    assign in_now     = r_in_data[31:0];
    assign in_pwr     = r_in_data[32];
    assign in_cnt     = r_in_data[48:33];
    assign in_key     = r_in_data[49];
    assign in_present = r_in_data[50];
    assign in_tx      = r_in_data[66:51];
    assign in_ty      = r_in_data[82:67];

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = uispc_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            uispc_pkg::REG_TIMEOUT:  prdata = {16'd0, r_timeout_s};
            uispc_pkg::REG_BRIGHT:   prdata = {25'd0, r_bright};
            uispc_pkg::REG_PKEY_DEB: prdata = {22'd0, r_pkey_deb};
            uispc_pkg::REG_EKEY_DEB: prdata = {22'd0, r_ekey_deb};
            default:                 prdata = 32'd0;
        endcase
    end

    // Backlight duty and timeout in milliseconds are worked out at write time.
    always_comb begin
        bright_eff = pwdata[6:0];
        if (bright_eff > uispc_pkg::BRIGHT_MAX) begin
            bright_eff = uispc_pkg::BRIGHT_MAX;
        end else if (bright_eff != 7'd0 && bright_eff < uispc_pkg::BRIGHT_MIN) begin
            bright_eff = uispc_pkg::BRIGHT_MIN;
        end
        duty_prod     = 15'({8'd0, bright_eff} * {7'd0, uispc_pkg::DUTY_FULL});
        duty_scaled   = 31'({16'd0, duty_prod} * {15'd0, uispc_pkg::DUTY_RECIP});
        timeout_ms_wr = 26'({10'd0, pwdata[15:0]} * 26'(uispc_pkg::MS_PER_SEC));
    end

    // Detent division: the magnitude is divided by a reciprocal that is exact
    // for every 16-bit dividend, so no correction step is needed.
    always_comb begin
        enc_delta    = in_cnt - r_enc_last;
        enc_acc      = {{(17 - REM_W){r_rem[REM_W-1]}}, r_rem} + {enc_delta[15], enc_delta};
        enc_neg      = enc_acc[16];
        enc_mag_full = enc_neg ? (17'd0 - enc_acc) : enc_acc;
        enc_mag      = enc_mag_full[15:0];
        enc_prod     = {22'd0, enc_mag} * {16'd0, DIV_RECIP};
        q_mag        = enc_prod[DIV_SHIFT +: 16];
        q_times_d    = {5'd0, q_mag} * {16'd0, DETENT_C};
        rem_mag      = enc_mag - q_times_d[15:0];
        q_signed     = enc_neg ? (17'd0 - {1'b0, q_mag}) : {1'b0, q_mag};
        rem_signed   = enc_neg ? (17'd0 - {1'b0, rem_mag}) : {1'b0, rem_mag};
        step_nonzero = (q_mag != 16'd0);
        if (!q_signed[16] && q_signed[15:14] != 2'b00) begin
            steps_sat = uispc_pkg::STEPS_MAX;
        end else if (q_signed[16] && q_signed[15:14] != 2'b11) begin
            steps_sat = uispc_pkg::STEPS_MIN;
        end else begin
            steps_sat = q_signed[14:0];
        end
    end

    always_comb begin
        n_off         = r_off;
        n_last_act    = r_restart ? in_now : r_last_act;
        n_restart     = 1'b0;
        n_pk_phase    = r_pk_phase;
        n_pk_since    = r_pk_since;
        n_enc_last    = r_enc_last;
        n_rem         = r_rem;
        n_ekey_raw    = r_ekey_raw;
        n_ekey_stable = r_ekey_stable;
        n_ekey_since  = r_ekey_since;
        n_swallow     = r_swallow;
        n_out         = '0;
        elapsed       = in_now - n_last_act;

        case (uispc_pkg::t_opcode'(r_in_op))
            uispc_pkg::OP_CHECK: begin
                if (!n_off && r_timeout_ms != '0
                        && elapsed > {6'd0, r_timeout_ms}) begin
                    n_off = 1'b1;
                end
                unique case (r_pk_phase)
                    uispc_pkg::PK_ARMED: begin
                        if (in_pwr) begin
                            n_pk_phase = uispc_pkg::PK_RELEASED;
                        end else if (in_now - r_pk_since >= {22'd0, r_pkey_deb}) begin
                            // A held key toggles the screen; waking counts as activity.
                            if (n_off) begin
                                n_off      = 1'b0;
                                n_last_act = in_now;
                            end else begin
                                n_off = 1'b1;
                            end
                            n_pk_phase = uispc_pkg::PK_HELD;
                        end
                    end
                    uispc_pkg::PK_HELD: begin
                        if (in_pwr) begin
                            n_pk_phase = uispc_pkg::PK_RELEASED;
                        end
                    end
                    default: begin
                        n_pk_phase = uispc_pkg::PK_RELEASED;
                        if (!in_pwr) begin
                            n_pk_phase = uispc_pkg::PK_ARMED;
                            n_pk_since = in_now;
                        end
                    end
                endcase
            end
            uispc_pkg::OP_ENCODER: begin
                n_rem      = rem_signed[REM_W-1:0];
                n_enc_last = in_cnt;
                n_out.encoder_steps = steps_sat;
                if (in_key != r_ekey_raw) begin
                    n_ekey_raw   = in_key;
                    n_ekey_since = in_now;
                end
                if (in_now - n_ekey_since >= {22'd0, r_ekey_deb}) begin
                    n_ekey_stable = in_key;
                end
                if (step_nonzero || (!n_ekey_stable && !in_key)) begin
                    n_off      = 1'b0;
                    n_last_act = in_now;
                end
            end
            uispc_pkg::OP_TOUCH: begin
                if (in_present) begin
                    // The touch that wakes the screen is swallowed until release.
                    if (n_off) begin
                        n_swallow = 1'b1;
                    end
                    n_off      = 1'b0;
                    n_last_act = in_now;
                    if (!n_swallow) begin
                        n_out.touch_pressed = 1'b1;
                        n_out.touch_x = (in_tx > X_MAX) ? X_MAX[8:0] : in_tx[8:0];
                        n_out.touch_y = (in_ty > Y_MAX) ? Y_MAX[7:0] : in_ty[7:0];
                    end
                end else begin
                    n_swallow = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_out.screen_is_off       = n_off;
        n_out.backlight_duty      = n_off ? 8'd0 : r_duty;
        n_out.encoder_key_pressed = !n_ekey_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_timeout_s   <= '0;
            r_timeout_ms  <= '0;
            r_bright      <= uispc_pkg::BRIGHT_RESET;
            r_duty        <= uispc_pkg::DUTY_FULL;
            r_pkey_deb    <= uispc_pkg::PKEY_DEB_RESET;
            r_ekey_deb    <= uispc_pkg::EKEY_DEB_RESET;
            r_off         <= 1'b0;
            r_last_act    <= '0;
            r_restart     <= 1'b0;
            r_pk_phase    <= uispc_pkg::PK_RELEASED;
            r_pk_since    <= '0;
            r_enc_last    <= '0;
            r_rem         <= '0;
            r_ekey_raw    <= 1'b1;
            r_ekey_stable <= 1'b1;
            r_ekey_since  <= '0;
            r_swallow     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_off         <= n_off;
                r_last_act    <= n_last_act;
                r_restart     <= n_restart;
                r_pk_phase    <= n_pk_phase;
                r_pk_since    <= n_pk_since;
                r_enc_last    <= n_enc_last;
                r_rem         <= n_rem;
                r_ekey_raw    <= n_ekey_raw;
                r_ekey_stable <= n_ekey_stable;
                r_ekey_since  <= n_ekey_since;
                r_swallow     <= n_swallow;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    uispc_pkg::REG_TIMEOUT: begin
                        // Writing the timeout wakes the screen and restarts the timer
                        // at the time stamp of the next word.
                        r_timeout_s  <= pwdata[15:0];
                        r_timeout_ms <= timeout_ms_wr;
                        r_off        <= 1'b0;
                        r_restart    <= 1'b1;
                    end
                    uispc_pkg::REG_BRIGHT: begin
                        r_bright <= pwdata[6:0];
                        r_duty   <= duty_scaled[uispc_pkg::DUTY_SHIFT +: 8];
                    end
                    uispc_pkg::REG_PKEY_DEB: begin
                        r_pkey_deb <= pwdata[9:0];
                    end
                    uispc_pkg::REG_EKEY_DEB: begin
                        r_ekey_deb <= pwdata[9:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
